// ----- rtl/rne_pkg.sv -----
// ----------------------------------------------------------------------------
// rne_pkg
// Types, constants and term tables shared by the Roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

  localparam int ValueW    = 12;
  localparam int SymbolW   = 8;
  localparam int TermCount = 13;
  localparam int TermIdxW  = $clog2(TermCount);

  localparam logic [ValueW-1:0] MaxValue = ValueW'(3999);

  localparam logic [SymbolW-1:0] ChNone = 8'h00;
  localparam logic [SymbolW-1:0] ChM    = 8'h4D;
  localparam logic [SymbolW-1:0] ChD    = 8'h44;
  localparam logic [SymbolW-1:0] ChC    = 8'h43;
  localparam logic [SymbolW-1:0] ChL    = 8'h4C;
  localparam logic [SymbolW-1:0] ChX    = 8'h58;
  localparam logic [SymbolW-1:0] ChV    = 8'h56;
  localparam logic [SymbolW-1:0] ChI    = 8'h49;

  typedef enum logic {
    StIdle,
    StEmit
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

  function automatic logic [ValueW-1:0] term_weight(input logic [TermIdxW-1:0] idx);
    logic [ValueW-1:0] w;
    case (idx)
      4'd0:    w = ValueW'(1000);
      4'd1:    w = ValueW'(900);
      4'd2:    w = ValueW'(500);
      4'd3:    w = ValueW'(400);
      4'd4:    w = ValueW'(100);
      4'd5:    w = ValueW'(90);
      4'd6:    w = ValueW'(50);
      4'd7:    w = ValueW'(40);
      4'd8:    w = ValueW'(10);
      4'd9:    w = ValueW'(9);
      4'd10:   w = ValueW'(5);
      4'd11:   w = ValueW'(4);
      4'd12:   w = ValueW'(1);
      default: w = ValueW'(1);
    endcase
    return w;
  endfunction

  function automatic logic [SymbolW-1:0] term_first(input logic [TermIdxW-1:0] idx);
    logic [SymbolW-1:0] c;
    case (idx)
      4'd0:    c = ChM;
      4'd1:    c = ChC;
      4'd2:    c = ChD;
      4'd3:    c = ChC;
      4'd4:    c = ChC;
      4'd5:    c = ChX;
      4'd6:    c = ChL;
      4'd7:    c = ChX;
      4'd8:    c = ChX;
      4'd9:    c = ChI;
      4'd10:   c = ChV;
      4'd11:   c = ChI;
      4'd12:   c = ChI;
      default: c = ChI;
    endcase
    return c;
  endfunction

  function automatic logic [SymbolW-1:0] term_second(input logic [TermIdxW-1:0] idx);
    logic [SymbolW-1:0] c;
    case (idx)
      4'd1:    c = ChM;
      4'd3:    c = ChD;
      4'd5:    c = ChC;
      4'd7:    c = ChL;
      4'd9:    c = ChX;
      4'd11:   c = ChV;
      default: c = ChNone;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/rne_if.sv -----
// ----------------------------------------------------------------------------
// rne_if
// Valid/ready channels for integer values in and numeral letters out.
// ----------------------------------------------------------------------------
interface rne_in_if;
  logic                       valid;
  logic                       ready;
  logic [rne_pkg::ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rne_out_if;
  logic                        valid;
  logic                        ready;
  logic [rne_pkg::SymbolW-1:0] symbol;
  logic                        last;
  logic                        error;

  modport source (output valid, output symbol, output last, output error, input ready);
  modport sink   (input valid, input symbol, input last, input error, output ready);
endinterface

// ----- rtl/roman_numeral_encoder.sv -----
// ----------------------------------------------------------------------------
// roman_numeral_encoder
// Converts a 12-bit integer to Roman numeral ASCII letters, one per transfer.
// The first letter is valid in the cycle after the value transfer.
// Letters go out one per cycle while the receiver is ready, 1 to 15 per value;
//   a new value is taken only once its last letter has transferred.
// Zero and out-of-range values give a single letter with error and last set.
// Reset returns the sequencer to idle at once; no clearing pass.
// ----------------------------------------------------------------------------
module roman_numeral_encoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  rne_in_if.sink    val_i,
  rne_out_if.source sym_o
);
  import rne_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rne_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (val_i.valid),
    .in_ready_o  (val_i.ready),
    .out_valid_o (sym_o.valid),
    .out_ready_i (sym_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rne_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .value_i  (val_i.value),
    .status_o (status),
    .symbol_o (sym_o.symbol),
    .last_o   (sym_o.last),
    .error_o  (sym_o.error)
  );

  a_load_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    val_i.valid && val_i.ready |=> sym_o.valid)
    else $error("no letter after value transfer");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_o.valid |-> !val_i.ready)
    else $error("value taken while letters pending");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_o.valid && sym_o.ready && sym_o.last |=> !sym_o.valid)
    else $error("letters continue after last");

  a_error_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_o.valid && sym_o.error |-> sym_o.last && (sym_o.symbol == ChNone))
    else $error("malformed error result");

endmodule

// ----- rtl/rne_ctrl.sv -----
// ----------------------------------------------------------------------------
// rne_ctrl
// Sequencer: takes a value, then steps the datapath once per letter transfer.
// ----------------------------------------------------------------------------
module rne_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  rne_pkg::dp_status_t status_i,
  output rne_pkg::dp_cmd_t    cmd_o
);
  import rne_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.advance = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StEmit;
        end
      end
      StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.last) begin
            state_d = StIdle;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// ----- rtl/rne_datapath.sv -----
// ----------------------------------------------------------------------------
// rne_datapath
// Remaining value, pending second letter and greedy term selection.
// ----------------------------------------------------------------------------
module rne_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rne_pkg::dp_cmd_t            cmd_i,
  input  logic [rne_pkg::ValueW-1:0]  value_i,
  output rne_pkg::dp_status_t         status_o,
  output logic [rne_pkg::SymbolW-1:0] symbol_o,
  output logic                        last_o,
  output logic                        error_o
);
  import rne_pkg::*;

  logic [ValueW-1:0]   rem_q, rem_d;
  logic [SymbolW-1:0]  pend_sym_q, pend_sym_d;
  logic                pend_q, pend_d;
  logic                err_q, err_d;
  logic [TermIdxW-1:0] sel;
  logic [ValueW-1:0]   rem_next;
  logic [SymbolW-1:0]  second;

  // pick the largest term not above the remaining value
  always_comb begin
    sel = TermIdxW'(TermCount - 1);
    for (int t = TermCount - 1; t >= 0; t--) begin
      if (rem_q >= term_weight(TermIdxW'(t))) begin
        sel = TermIdxW'(t);
      end
    end
  end

  assign rem_next = rem_q - term_weight(sel);
  assign second   = term_second(sel);

  always_comb begin
    if (err_q) begin
      symbol_o = ChNone;
      last_o   = 1'b1;
    end else if (pend_q) begin
      symbol_o = pend_sym_q;
      last_o   = (rem_q == '0);
    end else begin
      symbol_o = term_first(sel);
      last_o   = (second == ChNone) && (rem_next == '0);
    end
  end

  assign error_o       = err_q;
  assign status_o.last = last_o;

  always_comb begin
    rem_d      = rem_q;
    pend_d     = pend_q;
    pend_sym_d = pend_sym_q;
    err_d      = err_q;
    if (cmd_i.load) begin
      rem_d  = value_i;
      pend_d = 1'b0;
      err_d  = (value_i == '0) || (value_i > MaxValue);
    end else if (cmd_i.advance) begin
      if (pend_q) begin
        pend_d = 1'b0;
      end else begin
        rem_d      = rem_next;
        pend_d     = (second != ChNone);
        pend_sym_d = second;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      err_q  <= 1'b0;
    end else begin
      pend_q <= pend_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    pend_sym_q <= pend_sym_d;
  end

endmodule

// ----- sim/tb_roman_numeral_encoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_roman_numeral_encoder
// Drives integer values into the Roman numeral encoder and checks every
// letter transfer against a predicted numeral: letters in order, last flag on
// the final letter, and a single error letter for zero or values above 3999.
// Sender and receiver idle at random in two mixes, then run without idling while
// the receiver holds off for a long stretch once so that the encoder stalls its input.
// ----------------------------------------------------------------------------
module tb_roman_numeral_encoder;
  import rne_pkg::*;

  localparam int          NumTerms   = 13;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldOff    = 300;
  localparam int unsigned DrainWait  = 40;
  localparam int unsigned RandPerMix = 32;

  localparam int unsigned RomanWeight [NumTerms] = '{
    1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1
  };
  localparam logic [SymbolW-1:0] RomanFirst [NumTerms] = '{
    ChM, ChC, ChD, ChC, ChC, ChX, ChL, ChX, ChX, ChI, ChV, ChI, ChI
  };
  localparam logic [SymbolW-1:0] RomanSecond [NumTerms] = '{
    ChNone, ChM, ChNone, ChD, ChNone, ChC, ChNone, ChL, ChNone, ChX, ChNone, ChV,
    ChNone
  };

  typedef struct packed {
    logic [SymbolW-1:0] symbol;
    logic               last;
    logic               error;
  } letter_t;

  class numeral_scoreboard;
    letter_t     letters_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_value(logic [ValueW-1:0] value);
      int unsigned rest;
      letter_t     l;
      if (value == '0 || value > MaxValue) begin
        l = '{symbol: ChNone, last: 1'b1, error: 1'b1};
        letters_q.push_back(l);
        return;
      end
      rest = 32'(value);
      for (int t = 0; t < NumTerms; t++) begin
        while (rest >= RomanWeight[t]) begin
          l = '{symbol: RomanFirst[t], last: 1'b0, error: 1'b0};
          letters_q.push_back(l);
          if (RomanSecond[t] != ChNone) begin
            l = '{symbol: RomanSecond[t], last: 1'b0, error: 1'b0};
            letters_q.push_back(l);
          end
          rest -= RomanWeight[t];
        end
      end
      letters_q[letters_q.size()-1].last = 1'b1;
    endfunction

    function void check_letter(logic [SymbolW-1:0] symbol, logic last, logic error);
      letter_t want;
      if (letters_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected letter symbol=%h last=%b error=%b",
                   $realtime, symbol, last, error);
        mismatches++;
        return;
      end
      want = letters_q.pop_front();
      if (want.symbol !== symbol || want.last !== last || want.error !== error) begin
        if (mismatches < 10)
          $display("%0t: mismatch exp symbol=%h last=%b error=%b, got symbol=%h last=%b error=%b",
                   $realtime, want.symbol, want.last, want.error, symbol, last, error);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return letters_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  rne_in_if  val_if ();
  rne_out_if sym_if ();

  roman_numeral_encoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .val_i  (val_if),
    .sym_o  (sym_if)
  );

  numeral_scoreboard numerals = new();

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        hold_req;
  logic        hold_done;
  int unsigned hold_left;
  int unsigned cycle_count;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin
    rst_ni       = 1'b0;
    val_if.valid = 1'b0;
    val_if.value = '0;
    sym_if.ready = 1'b0;
    rx_idle_pct  = 0;
    hold_req     = 1'b0;
    hold_done    = 1'b0;
    hold_left    = 0;
    cycle_count  = 0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: check each letter transfer, then choose ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (sym_if.valid && sym_if.ready)
        numerals.check_letter(sym_if.symbol, sym_if.last, sym_if.error);
      if (hold_left != 0) begin
        hold_left--;
        sym_if.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldOff - 1;
        sym_if.ready <= 1'b0;
      end else begin
        sym_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_value(logic [ValueW-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      val_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    val_if.valid <= 1'b1;
    val_if.value <= value;
    do
      @(posedge clk_i);
    while (!val_if.ready);
    numerals.note_value(value);
  endtask

  function automatic logic [ValueW-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70)
      return ValueW'($urandom_range(3999, 1));
    else if (roll < 80)
      return ValueW'($urandom_range(50, 1));
    else if (roll < 88)
      return ValueW'(3000 + $urandom_range(999));
    else if (roll < 92)
      return '0;
    else
      return ValueW'($urandom_range(4095, 4000));
  endfunction

  task automatic send_random(int unsigned count);
    repeat (count) send_value(pick_value());
  endtask

  initial begin
    logic [ValueW-1:0] directed [$];
    directed = '{0, 4095, 4000, 3999, 1, 3888, 4, 9, 40, 90, 400, 900, 3, 5, 10,
                 50, 100, 500, 1000, 1994, 2048, 1365, 2730, 444, 999};

    tx_idle_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni      <= 1'b1;
    rx_idle_pct <= 75;
    tx_idle_pct = 35;
    @(posedge clk_i);

    foreach (directed[i]) send_value(directed[i]);
    send_random(RandPerMix);

    tx_idle_pct = 75;
    rx_idle_pct <= 35;
    send_random(RandPerMix);

    // stall the output while values keep coming
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req    <= 1'b1;
    send_random(RandPerMix);
    val_if.valid <= 1'b0;

    while (numerals.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (numerals.mismatches == 0 && numerals.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
